// ===== rtl/core/src_pkg.sv =====
// shared types, codes and size tables for the sprite row/column coverage block
// no dependencies; used by src_attr_mem and the top level
package src_pkg;

  // request kinds
  typedef enum logic [1:0] {
    KIND_DRAW = 2'd0,
    KIND_HIDE = 2'd1,
    KIND_READ = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  // full width of a returned coverage bitmap, two 64-bit halves
  localparam int BITMAP_BITS = 128;
  localparam int HALF_BITS   = 64;

  // stored sprite attributes, written on draw and read back on hide
  typedef struct packed {
    logic signed [8:0] left;
    logic        [6:0] base_width;
    logic signed [8:0] top;
    logic        [6:0] base_height;
  } attr_t;

  // base dimension tables indexed by shape then size; empty shape gives 0
  localparam logic [6:0] WIDTH_TAB [4][4] = '{
    '{7'd8,  7'd16, 7'd32, 7'd64},
    '{7'd16, 7'd32, 7'd32, 7'd64},
    '{7'd8,  7'd8,  7'd16, 7'd32},
    '{7'd0,  7'd0,  7'd0,  7'd0}
  };

  localparam logic [6:0] HEIGHT_TAB [4][4] = '{
    '{7'd8,  7'd16, 7'd32, 7'd64},
    '{7'd8,  7'd8,  7'd16, 7'd32},
    '{7'd16, 7'd32, 7'd32, 7'd64},
    '{7'd0,  7'd0,  7'd0,  7'd0}
  };

endpackage

// ===== rtl/core/src_attr_mem.sv =====
// per-sprite attribute table: one write port, one registered read port
// depends on src_pkg for attr_t; entries read as zero until first written
module src_attr_mem #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output src_pkg::attr_t    rd_data,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  src_pkg::attr_t    wr_data
);

  src_pkg::attr_t mem [DEPTH];
  logic [DEPTH-1:0] valid;
  src_pkg::attr_t rd_word;
  logic rd_valid;

  // storage array, written and read on the clock
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_word <= mem[rd_addr];
    end
  end

  // written flags, cleared by reset so untouched entries read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= valid[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid ? rd_word : '0;

endmodule

// ===== rtl/core/src_cover_mem.sv =====
// coverage row memory: one row of sprite bits per screen column or line
// no package use; rows read as all clear until first written after reset
module src_cover_mem #(
  parameter int ROWS  = 240,
  parameter int WIDTH = 128,
  parameter int AW    = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [ROWS];
  logic [ROWS-1:0]  valid;
  logic [WIDTH-1:0] rd_word;
  logic             rd_valid;

  // row storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_word <= mem[rd_addr];
    end
  end

  // per-row written flags
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= valid[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid ? rd_word : '0;

endmodule

// ===== rtl/core/src_clip.sv =====
// clips a span [start, start + len) to [0, LIMIT] on one screen axis
// no package use; instantiated once per axis by the top level
module src_clip #(
  parameter int LIMIT = 240
) (
  input  logic signed [8:0] start,
  input  logic        [7:0] len,
  output logic        [8:0] span_from,
  output logic        [8:0] span_to
);

  localparam logic signed [9:0] LIM = 10'(LIMIT);

  logic signed [9:0] start_ext;
  logic signed [9:0] end_ext;
  logic        [8:0] from_c;

  assign start_ext = 10'(start);
  assign end_ext   = start_ext + $signed({2'b00, len});

  // clamp both ends, then keep from no higher than to
  always_comb begin
    if (end_ext < 0) begin
      span_to = '0;
    end else if (end_ext > LIM) begin
      span_to = LIM[8:0];
    end else begin
      span_to = end_ext[8:0];
    end

    if (start_ext < 0) begin
      from_c = '0;
    end else if (start_ext > LIM) begin
      from_c = LIM[8:0];
    end else begin
      from_c = start_ext[8:0];
    end

    span_from = (from_c > span_to) ? span_to : from_c;
  end

endmodule

// ===== rtl/core/sprite_row_column_coverage.sv =====
// top level: request decode, sweep sequencer and result register
// depends on src_pkg, src_attr_mem, src_cover_mem and src_clip

// Keeps a bitmap of covering sprites for every screen column and line. A draw
// sets the sprite's bit over its clipped column span and then its clipped line
// span; a hide clears the span stored at the draw, sized by the hide's own
// double flag; a read returns one column or line bitmap. One request is worked
// at a time and req_stall is high until it has been handed to the result
// register. All coverage updates go through one read-modify-write unit that
// reads each covered position and then writes it back, on row memories with
// one read and one write port. The result register lets the next request in
// while a result waits. Per-row written flags clear all bitmaps at reset, so
// no clearing pass is run.
module sprite_row_column_coverage #(
  parameter int FRAME_WIDTH  = 240,
  parameter int FRAME_HEIGHT = 160,
  parameter int SPRITE_COUNT = 128
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic [1:0]                    kind,
  input  logic [6:0]                    sprite_index,
  input  logic                          affine_mode,
  input  logic                          double_or_disable,
  input  logic [1:0]                    shape_code,
  input  logic [1:0]                    size_code,
  input  logic signed [8:0]             x_position,
  input  logic [7:0]                    y_byte,
  input  logic                          read_axis,
  input  logic [7:0]                    read_position,
  output logic                          res_valid,
  input  logic                          res_stall,
  output logic                          skipped,
  output logic [7:0]                    x_from,
  output logic [7:0]                    x_to,
  output logic [7:0]                    y_from,
  output logic [7:0]                    y_to,
  output logic [src_pkg::HALF_BITS-1:0] bitmap_low,
  output logic [src_pkg::HALF_BITS-1:0] bitmap_high
);

  localparam int IW  = (SPRITE_COUNT > 1) ? $clog2(SPRITE_COUNT) : 1;
  localparam int CAW = (FRAME_WIDTH > 1) ? $clog2(FRAME_WIDTH) : 1;
  localparam int LAW = (FRAME_HEIGHT > 1) ? $clog2(FRAME_HEIGHT) : 1;

  typedef enum logic [7:0] {
    ST_IDLE    = 8'b00000001,
    ST_SPAN    = 8'b00000010,
    ST_COL_RD  = 8'b00000100,
    ST_COL_WR  = 8'b00001000,
    ST_LIN_RD  = 8'b00010000,
    ST_LIN_WR  = 8'b00100000,
    ST_RD_WAIT = 8'b01000000,
    ST_FINISH  = 8'b10000000
  } state_t;

  state_t state, state_next;

  // latched request
  src_pkg::kind_t    cur_kind;
  logic [IW-1:0]     cur_idx;
  logic              cur_flag;
  logic [1:0]        cur_shape;
  logic [1:0]        cur_size;
  logic signed [8:0] cur_x;
  logic [7:0]        cur_y;
  logic              cur_axis;
  logic              cur_in_range;

  // staged result and sweep state
  logic                            res_skip;
  logic [8:0]                      span_x_from, span_x_to, span_y_from, span_y_to;
  logic [src_pkg::BITMAP_BITS-1:0] res_bitmap;
  logic [8:0]                      pos;

  logic accept;
  logic req_disabled;
  logic req_in_range;
  logic load_out;

  src_pkg::attr_t attr_rd, attr_wr;
  logic [SPRITE_COUNT-1:0] col_rd, lin_rd, row_mask, col_wr_data, lin_wr_data;
  logic col_rd_en, col_wr_en, lin_rd_en, lin_wr_en;
  logic [CAW-1:0] col_rd_addr;
  logic [LAW-1:0] lin_rd_addr;

  logic [6:0] tab_w, tab_h;
  logic [7:0] base_w_ext, base_h_ext, len_w, len_h;
  logic signed [8:0] y_signed, y_start, x_start;
  logic signed [9:0] y_bottom;
  logic [8:0] clip_x_from, clip_x_to, clip_y_from, clip_y_to;
  logic set_bit;

  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;

  // disabled sprite or index past the table
  assign req_disabled = (!affine_mode && double_or_disable) ||
                        ({1'b0, sprite_index} >= 8'(SPRITE_COUNT));
  assign req_in_range = read_axis ? ({1'b0, read_position} < 9'(FRAME_HEIGHT))
                                  : ({1'b0, read_position} < 9'(FRAME_WIDTH));

  // span sources: request fields on draw, stored attributes on hide
  assign tab_w = src_pkg::WIDTH_TAB[cur_shape][cur_size];
  assign tab_h = src_pkg::HEIGHT_TAB[cur_shape][cur_size];

  always_comb begin
    if (cur_kind == src_pkg::KIND_DRAW) begin
      base_w_ext = {1'b0, tab_w};
      base_h_ext = {1'b0, tab_h};
    end else begin
      base_w_ext = {1'b0, attr_rd.base_width};
      base_h_ext = {1'b0, attr_rd.base_height};
    end
    len_w = base_w_ext << cur_flag;
    len_h = base_h_ext << cur_flag;
  end

  // a sprite wholly above the screen takes its top byte as unsigned
  assign y_signed = {cur_y[7], cur_y};
  assign y_bottom = 10'(y_signed) + $signed({2'b00, len_h});

  always_comb begin
    if (cur_kind == src_pkg::KIND_DRAW) begin
      x_start = cur_x;
      y_start = y_bottom[9] ? $signed({1'b0, cur_y}) : y_signed;
    end else begin
      x_start = attr_rd.left;
      y_start = attr_rd.top;
    end
  end

  src_clip #(.LIMIT(FRAME_WIDTH)) u_clip_x (
    .start     (x_start),
    .len       (len_w),
    .span_from (clip_x_from),
    .span_to   (clip_x_to)
  );

  src_clip #(.LIMIT(FRAME_HEIGHT)) u_clip_y (
    .start     (y_start),
    .len       (len_h),
    .span_from (clip_y_from),
    .span_to   (clip_y_to)
  );

  // attribute table: read on hide request, written on draw span
  assign attr_wr.left        = x_start;
  assign attr_wr.base_width  = tab_w;
  assign attr_wr.top         = y_start;
  assign attr_wr.base_height = tab_h;

  src_attr_mem #(.DEPTH(SPRITE_COUNT), .AW(IW)) u_attr (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept && (kind == src_pkg::KIND_HIDE)),
    .rd_addr (sprite_index[IW-1:0]),
    .rd_data (attr_rd),
    .wr_en   ((state == ST_SPAN) && (cur_kind == src_pkg::KIND_DRAW)),
    .wr_addr (cur_idx),
    .wr_data (attr_wr)
  );

  // shared read-modify-write unit: set on draw, clear on hide
  assign set_bit     = (cur_kind == src_pkg::KIND_DRAW);
  assign row_mask    = SPRITE_COUNT'(1) << cur_idx;
  assign col_wr_data = set_bit ? (col_rd | row_mask) : (col_rd & ~row_mask);
  assign lin_wr_data = set_bit ? (lin_rd | row_mask) : (lin_rd & ~row_mask);

  assign col_rd_en   = (accept && (kind == src_pkg::KIND_READ) && !read_axis &&
                        req_in_range) ||
                       ((state == ST_COL_RD) && (pos != span_x_to));
  assign lin_rd_en   = (accept && (kind == src_pkg::KIND_READ) && read_axis &&
                        req_in_range) ||
                       ((state == ST_LIN_RD) && (pos != span_y_to));
  assign col_rd_addr = (state == ST_IDLE) ? read_position[CAW-1:0] : pos[CAW-1:0];
  assign lin_rd_addr = (state == ST_IDLE) ? read_position[LAW-1:0] : pos[LAW-1:0];
  assign col_wr_en   = (state == ST_COL_WR);
  assign lin_wr_en   = (state == ST_LIN_WR);

  src_cover_mem #(.ROWS(FRAME_WIDTH), .WIDTH(SPRITE_COUNT), .AW(CAW)) u_col (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (col_rd_en),
    .rd_addr (col_rd_addr),
    .rd_data (col_rd),
    .wr_en   (col_wr_en),
    .wr_addr (pos[CAW-1:0]),
    .wr_data (col_wr_data)
  );

  src_cover_mem #(.ROWS(FRAME_HEIGHT), .WIDTH(SPRITE_COUNT), .AW(LAW)) u_lin (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (lin_rd_en),
    .rd_addr (lin_rd_addr),
    .rd_data (lin_rd),
    .wr_en   (lin_wr_en),
    .wr_addr (pos[LAW-1:0]),
    .wr_data (lin_wr_data)
  );

  assign load_out = (state == ST_FINISH) && (!res_valid || !res_stall);

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (kind)
            src_pkg::KIND_DRAW, src_pkg::KIND_HIDE: begin
              state_next = req_disabled ? ST_FINISH : ST_SPAN;
            end
            src_pkg::KIND_READ: state_next = ST_RD_WAIT;
            default:            state_next = ST_FINISH;
          endcase
        end
      end
      ST_SPAN:    state_next = ST_COL_RD;
      ST_COL_RD:  state_next = (pos == span_x_to) ? ST_LIN_RD : ST_COL_WR;
      ST_COL_WR:  state_next = ST_COL_RD;
      ST_LIN_RD:  state_next = (pos == span_y_to) ? ST_FINISH : ST_LIN_WR;
      ST_LIN_WR:  state_next = ST_LIN_RD;
      ST_RD_WAIT: state_next = ST_FINISH;
      ST_FINISH:  state_next = load_out ? ST_IDLE : ST_FINISH;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // request capture, span staging and sweep position
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_kind     <= src_pkg::kind_t'(kind);
      cur_idx      <= sprite_index[IW-1:0];
      cur_flag     <= double_or_disable;
      cur_shape    <= shape_code;
      cur_size     <= size_code;
      cur_x        <= x_position;
      cur_y        <= y_byte;
      cur_axis     <= read_axis;
      cur_in_range <= req_in_range;
      res_skip     <= req_disabled &&
                      ((kind == src_pkg::KIND_DRAW) || (kind == src_pkg::KIND_HIDE));
      span_x_from  <= '0;
      span_x_to    <= '0;
      span_y_from  <= '0;
      span_y_to    <= '0;
      res_bitmap   <= '0;
    end
    case (state)
      ST_SPAN: begin
        span_x_from <= clip_x_from;
        span_x_to   <= clip_x_to;
        span_y_from <= clip_y_from;
        span_y_to   <= clip_y_to;
        pos         <= clip_x_from;
      end
      ST_COL_RD: begin
        if (pos == span_x_to) begin
          pos <= span_y_from;
        end
      end
      ST_COL_WR, ST_LIN_WR: pos <= pos + 9'd1;
      ST_RD_WAIT: begin
        if (cur_in_range) begin
          res_bitmap <= cur_axis ? src_pkg::BITMAP_BITS'(lin_rd)
                                 : src_pkg::BITMAP_BITS'(col_rd);
        end
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_out) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      skipped     <= res_skip;
      x_from      <= span_x_from[7:0];
      x_to        <= span_x_to[7:0];
      y_from      <= span_y_from[7:0];
      y_to        <= span_y_to[7:0];
      bitmap_low  <= res_bitmap[src_pkg::HALF_BITS-1:0];
      bitmap_high <= res_bitmap[src_pkg::BITMAP_BITS-1:src_pkg::HALF_BITS];
    end
  end

`ifndef SYNTHESIS
  // column sweep stays inside its clipped span
  a_col_pos: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COL_RD) |-> (pos >= span_x_from) && (pos <= span_x_to))
    else $error("column sweep position left its span");

  // line sweep stays inside its clipped span
  a_lin_pos: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LIN_RD) |-> (pos >= span_y_from) && (pos <= span_y_to))
    else $error("line sweep position left its span");

  // a skipped request never carries a span or a bitmap
  a_skip_clean: assert property (@(posedge clk) disable iff (rst)
    (res_valid && skipped) |->
      (x_from == 8'd0) && (x_to == 8'd0) && (y_from == 8'd0) && (y_to == 8'd0) &&
      (bitmap_low == '0) && (bitmap_high == '0))
    else $error("skipped result carries data");

  // a new result only appears out of the finish step
  a_load_src: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state == ST_FINISH))
    else $error("result raised outside the finish step");

  // the cover memories are only written during a draw or hide sweep
  a_wr_kind: assert property (@(posedge clk) disable iff (rst)
    (col_wr_en || lin_wr_en) |->
      ((cur_kind == src_pkg::KIND_DRAW) || (cur_kind == src_pkg::KIND_HIDE)) && !res_skip)
    else $error("coverage write outside a draw or hide");
`endif

endmodule

// ===== test/sprite_row_column_coverage_tb.sv =====
// testbench for sprite_row_column_coverage: draw, hide and read requests with a
// built-in coverage predictor, random gaps on both sides and a long result hold
// depends on src_pkg and the sprite_row_column_coverage rtl
`timescale 1ns / 1ps

module sprite_row_column_coverage_tb;

  localparam int FRAME_WIDTH    = 240;
  localparam int FRAME_HEIGHT   = 160;
  localparam int SPRITE_COUNT   = 128;
  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 9;
  localparam int DRAIN_CYCLES   = 600;
  localparam int HOLD_CYCLES    = 400;
  localparam int TIMEOUT_CYCLES = 1_500_000;
  localparam int RANDOM_ITEMS   = 360;

  typedef struct {
    src_pkg::kind_t    kind;
    logic [6:0]        sprite;
    logic              affine;
    logic              dbl;
    logic [1:0]        shape;
    logic [1:0]        size;
    logic signed [8:0] x;
    logic [7:0]        y;
    logic              axis;
    logic [7:0]        pos;
  } coverage_request_t;

  typedef struct {
    logic        skipped;
    logic [7:0]  x_from;
    logic [7:0]  x_to;
    logic [7:0]  y_from;
    logic [7:0]  y_to;
    logic [63:0] low;
    logic [63:0] high;
  } coverage_result_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              req_valid;
  logic              req_stall;
  logic [1:0]        kind;
  logic [6:0]        sprite_index;
  logic              affine_mode;
  logic              double_or_disable;
  logic [1:0]        shape_code;
  logic [1:0]        size_code;
  logic signed [8:0] x_position;
  logic [7:0]        y_byte;
  logic              read_axis;
  logic [7:0]        read_position;
  logic              res_valid;
  logic              res_stall;
  logic              skipped;
  logic [7:0]        x_from;
  logic [7:0]        x_to;
  logic [7:0]        y_from;
  logic [7:0]        y_to;
  logic [63:0]       bitmap_low;
  logic [63:0]       bitmap_high;

  // predictor state: stored sprite spans and per-position coverage bitmaps
  int       stored_left [SPRITE_COUNT];
  int       stored_top [SPRITE_COUNT];
  int       stored_width [SPRITE_COUNT];
  int       stored_height [SPRITE_COUNT];
  bit [127:0] column_cover [FRAME_WIDTH];
  bit [127:0] line_cover [FRAME_HEIGHT];

  coverage_result_t pending_results[$];
  int error_count = 0;
  bit sender_gaps = 1'b1;
  bit receiver_stalls = 1'b1;
  bit hold_request = 1'b0;

  sprite_row_column_coverage #(
    .FRAME_WIDTH (FRAME_WIDTH),
    .FRAME_HEIGHT(FRAME_HEIGHT),
    .SPRITE_COUNT(SPRITE_COUNT)
  ) i_dut (
    .clk              (clk),
    .rst              (rst),
    .req_valid        (req_valid),
    .req_stall        (req_stall),
    .kind             (kind),
    .sprite_index     (sprite_index),
    .affine_mode      (affine_mode),
    .double_or_disable(double_or_disable),
    .shape_code       (shape_code),
    .size_code        (size_code),
    .x_position       (x_position),
    .y_byte           (y_byte),
    .read_axis        (read_axis),
    .read_position    (read_position),
    .res_valid        (res_valid),
    .res_stall        (res_stall),
    .skipped          (skipped),
    .x_from           (x_from),
    .x_to             (x_to),
    .y_from           (y_from),
    .y_to             (y_to),
    .bitmap_low       (bitmap_low),
    .bitmap_high      (bitmap_high)
  );

  always #(CLK_PERIOD / 2.0) clk = ~clk;

  // base sprite dimension from shape and size, empty shape gives 0
  function automatic int base_dim(logic [1:0] shape, logic [1:0] size, bit vertical);
    int long_side;
    int short_side;
    long_side  = (size == 2'd0) ? 16 : (size == 2'd3) ? 64 : 32;
    short_side = (size == 2'd0) ? 8 : (size == 2'd1) ? 8 : (size == 2'd2) ? 16 : 32;
    case (shape)
      2'd0:    return 8 << size;
      2'd1:    return vertical ? short_side : long_side;
      2'd2:    return vertical ? long_side : short_side;
      default: return 0;
    endcase
  endfunction

  // clip [start, stop) to the frame and set or clear the sprite's bit over it
  function automatic void mark_span(bit on_lines, int start, int stop, int sprite, bit set,
                                    output logic [7:0] from8, output logic [7:0] to8);
    int lim;
    int lo;
    int hi;
    lim = on_lines ? FRAME_HEIGHT : FRAME_WIDTH;
    hi  = (stop < 0) ? 0 : (stop > lim) ? lim : stop;
    lo  = (start < 0) ? 0 : (start > lim) ? lim : start;
    if (lo > hi) lo = hi;
    for (int p = lo; p < hi; p++) begin
      if (on_lines) line_cover[p][sprite] = set;
      else column_cover[p][sprite] = set;
    end
    from8 = lo[7:0];
    to8   = hi[7:0];
  endfunction

  // expected result of one request, updating the predicted coverage state
  function automatic coverage_result_t predict_coverage(coverage_request_t r);
    coverage_result_t res;
    int x0;
    int y0;
    int rw;
    int rh;
    int lim;
    bit [127:0] word;
    res = '{default: '0};
    case (r.kind)
      src_pkg::KIND_READ: begin
        lim = r.axis ? FRAME_HEIGHT : FRAME_WIDTH;
        if (int'(r.pos) < lim) begin
          word = r.axis ? line_cover[r.pos] : column_cover[r.pos];
          res.low  = word[63:0];
          res.high = word[127:64];
        end
      end
      src_pkg::KIND_DRAW, src_pkg::KIND_HIDE: begin
        if (!r.affine && r.dbl) begin
          res.skipped = 1'b1;
        end else begin
          if (r.kind == src_pkg::KIND_DRAW) begin
            x0 = int'(r.x);
            stored_width[r.sprite]  = base_dim(r.shape, r.size, 1'b0);
            stored_height[r.sprite] = base_dim(r.shape, r.size, 1'b1);
            rh = stored_height[r.sprite] << r.dbl;
            // y byte is signed unless that puts the whole sprite above the frame
            y0 = r.y[7] ? int'(r.y) - 256 : int'(r.y);
            if (y0 + rh < 0) y0 = int'(r.y);
            stored_left[r.sprite] = x0;
            stored_top[r.sprite]  = y0;
          end
          // hide sizes the stored span by its own double flag
          rw = stored_width[r.sprite] << r.dbl;
          rh = stored_height[r.sprite] << r.dbl;
          x0 = stored_left[r.sprite];
          y0 = stored_top[r.sprite];
          mark_span(1'b0, x0, x0 + rw, int'(r.sprite), r.kind == src_pkg::KIND_DRAW,
                    res.x_from, res.x_to);
          mark_span(1'b1, y0, y0 + rh, int'(r.sprite), r.kind == src_pkg::KIND_DRAW,
                    res.y_from, res.y_to);
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // mostly short idle stretches, a few long ones
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic coverage_request_t random_request();
    coverage_request_t r;
    int sel;
    int pool;
    sel  = $urandom_range(0, 99);
    pool = $urandom_range(0, 15);
    r.kind   = (sel < 45) ? src_pkg::KIND_DRAW :
               (sel < 65) ? src_pkg::KIND_HIDE :
               (sel < 95) ? src_pkg::KIND_READ : src_pkg::KIND_NONE;
    // a small pool of sprites so hides and reads meet earlier draws
    r.sprite = ($urandom_range(0, 9) < 7) ? 7'((pool < 8) ? pool : pool + 112)
                                          : 7'($urandom);
    r.affine = 1'($urandom);
    r.dbl    = 1'($urandom);
    r.shape  = 2'($urandom);
    r.size   = 2'($urandom);
    r.x      = 9'($urandom);
    r.y      = 8'($urandom);
    r.axis   = 1'($urandom);
    r.pos    = 8'($urandom);
    if (r.kind == src_pkg::KIND_DRAW && !r.affine && r.dbl && $urandom_range(0, 3) != 0)
      r.dbl = 1'b0;
    if (r.kind == src_pkg::KIND_READ && $urandom_range(0, 99) < 85)
      r.pos = 8'($urandom_range(0, (r.axis ? FRAME_HEIGHT : FRAME_WIDTH) - 1));
    return r;
  endfunction

  function automatic coverage_request_t make_draw(int sprite, bit affine, bit dbl, int shape,
                                                  int size, int x, int y);
    coverage_request_t r;
    r = random_request();
    r.kind   = src_pkg::KIND_DRAW;
    r.sprite = 7'(sprite);
    r.affine = affine;
    r.dbl    = dbl;
    r.shape  = 2'(shape);
    r.size   = 2'(size);
    r.x      = 9'(x);
    r.y      = 8'(y);
    return r;
  endfunction

  function automatic coverage_request_t make_hide(int sprite, bit affine, bit dbl);
    coverage_request_t r;
    r = random_request();
    r.kind   = src_pkg::KIND_HIDE;
    r.sprite = 7'(sprite);
    r.affine = affine;
    r.dbl    = dbl;
    return r;
  endfunction

  function automatic coverage_request_t make_read(bit axis, int pos);
    coverage_request_t r;
    r = random_request();
    r.kind = src_pkg::KIND_READ;
    r.axis = axis;
    r.pos  = 8'(pos);
    return r;
  endfunction

  // offer one request after an optional gap and record its expected result
  task automatic send_request(coverage_request_t r);
    int gap;
    gap = (sender_gaps && $urandom_range(0, 9) < 6) ? idle_length() : 0;
    @(negedge clk);
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    kind              <= r.kind;
    sprite_index      <= r.sprite;
    affine_mode       <= r.affine;
    double_or_disable <= r.dbl;
    shape_code        <= r.shape;
    size_code         <= r.size;
    x_position        <= r.x;
    y_byte            <= r.y;
    read_axis         <= r.axis;
    read_position     <= r.pos;
    req_valid         <= 1'b1;
    do @(posedge clk); while (req_stall);
    pending_results.push_back(predict_coverage(r));
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endtask

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    coverage_result_t want;
    if (!rst && res_valid && !res_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("skipped", 64'(want.skipped), 64'(skipped));
        check_field("x_from", 64'(want.x_from), 64'(x_from));
        check_field("x_to", 64'(want.x_to), 64'(x_to));
        check_field("y_from", 64'(want.y_from), 64'(y_from));
        check_field("y_to", 64'(want.y_to), 64'(y_to));
        check_field("bitmap_low", want.low, bitmap_low);
        check_field("bitmap_high", want.high, bitmap_high);
      end
    end
  end

  // result side: random stall stretches, or one long hold when asked
  initial begin
    bit stalling;
    int stretch_left;
    stalling     = 1'b0;
    stretch_left = 0;
    res_stall <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        res_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        res_stall <= 1'b0;
      end else if (!receiver_stalls) begin
        res_stall <= 1'b0;
      end else begin
        if (stretch_left == 0) begin
          stalling     = ($urandom_range(0, 2) == 0);
          stretch_left = stalling ? idle_length() : $urandom_range(1, 12);
        end
        stretch_left--;
        res_stall <= stalling;
      end
    end
  end

  // extremes of position, size and flags plus every special case
  task automatic test_directed();
    coverage_request_t none_req;
    none_req      = random_request();
    none_req.kind = src_pkg::KIND_NONE;
    send_request(make_read(1'b0, 0));
    send_request(make_draw(0, 1'b0, 1'b0, 0, 0, 0, 0));
    send_request(make_read(1'b0, 0));
    send_request(make_read(1'b1, 7));
    send_request(make_read(1'b1, 8));
    // doubled 64x64 clipped at the right, bottom exactly meets line 0
    send_request(make_draw(127, 1'b1, 1'b1, 0, 3, 200, 8'h80));
    // fully left of the frame, top just above line 0
    send_request(make_draw(64, 1'b1, 1'b1, 1, 3, -256, 8'hFF));
    // fully right of the frame, wholly above so y reads unsigned
    send_request(make_draw(63, 1'b0, 1'b0, 2, 3, 255, 8'h90));
    // empty shape and left edge straddle
    send_request(make_draw(1, 1'b0, 1'b0, 3, 2, 10, 10));
    send_request(make_draw(2, 1'b1, 1'b0, 0, 1, -1, 152));
    // disabled sprite on draw and hide
    send_request(make_draw(3, 1'b0, 1'b1, 0, 3, 20, 20));
    send_request(make_hide(0, 1'b0, 1'b1));
    send_request(make_read(1'b0, 239));
    send_request(make_read(1'b1, 159));
    send_request(make_read(1'b1, 62));
    // hide with a different double flag than the draw used
    send_request(make_draw(126, 1'b1, 1'b1, 0, 1, 100, 40));
    send_request(make_hide(126, 1'b1, 1'b0));
    send_request(make_read(1'b0, 100));
    send_request(make_read(1'b0, 120));
    // hide of a sprite never drawn
    send_request(make_hide(5, 1'b1, 1'b1));
    // reads beyond the frame
    send_request(make_read(1'b0, 240));
    send_request(make_read(1'b1, 160));
    send_request(make_read(1'b0, 255));
    send_request(none_req);
  endtask

  task automatic test_random_traffic();
    for (int i = 0; i < RANDOM_ITEMS; i++) send_request(random_request());
  endtask

  // long result hold while requests keep coming back to back
  task automatic test_result_backpressure();
    sender_gaps  = 1'b0;
    hold_request = 1'b1;
    for (int i = 0; i < 12; i++) send_request(random_request());
    sender_gaps = 1'b1;
  endtask

  task automatic test_no_idle();
    sender_gaps     = 1'b0;
    receiver_stalls = 1'b0;
    for (int i = 0; i < 50; i++) send_request(random_request());
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
  endtask

  initial begin
    rst               <= 1'b1;
    req_valid         <= 1'b0;
    kind              <= src_pkg::KIND_NONE;
    sprite_index      <= '0;
    affine_mode       <= 1'b0;
    double_or_disable <= 1'b0;
    shape_code        <= '0;
    size_code         <= '0;
    x_position        <= '0;
    y_byte            <= '0;
    read_axis         <= 1'b0;
    read_position     <= '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_traffic();
    test_result_backpressure();
    test_no_idle();

    @(negedge clk);
    req_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // run limit
  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("Test completed with failures");
    $finish;
  end

endmodule
